### hdl/rspd_pkg.sv
// shared types, constants and helper functions for the remote switch pulse decoder
// no dependencies; imported by every module of the block
package rspd_pkg;

    localparam int PULSE_W    = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int GAP_W      = 5;
    localparam int MIL_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int SENDER_W   = 11;
    localparam int TOP_W      = SENDER_W + 1;

    localparam int MSG_BITS   = 32;
    localparam int HELD_BITS  = (MSG_BITS < 32) ? MSG_BITS : 32;
    localparam int BITS_W     = $clog2(MSG_BITS + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LATCH1    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH2    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT0      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIT1      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP   = 3'd5;

    // register reset values
    localparam logic [CFG_W-1:0] RST_LATCH1    = 16'd10000;
    localparam logic [CFG_W-1:0] RST_LATCH2    = 16'd2700;
    localparam logic [CFG_W-1:0] RST_BIT0      = 16'd300;
    localparam logic [CFG_W-1:0] RST_BIT1      = 16'd1300;
    localparam logic [CFG_W-1:0] RST_TOLERANCE = 16'd200;
    localparam logic [MIL_W-1:0] RST_MAX_GAP   = 4'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PAIR  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_LATCH2 = 2'd2;

    // symbol codes, pending half is symbol + 1, zero means nothing pending
    localparam logic [1:0] SYM_ZERO = 2'd0;
    localparam logic [1:0] SYM_ONE  = 2'd1;
    localparam logic [1:0] SYM_BAD  = 2'd2;
    localparam logic [1:0] HALF_NONE = 2'd0;

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'b001,
        PH_HUNT2 = 3'b010,
        PH_DATA  = 3'b100
    } phase_t;

    // classification of one pulse against every nominal length
    typedef struct packed {
        logic near_l1;
        logic near_l2;
        logic near_b0;
        logic near_b1;
    } pulse_class_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

    function automatic logic near_len(
        input logic [PULSE_W-1:0] p,
        input logic [CFG_W-1:0]   nominal,
        input logic [CFG_W-1:0]   tol
    );
        logic [PULSE_W-1:0] d;
        begin
            d = (p >= nominal) ? (p - nominal) : (nominal - p);
            return d <= tol;
        end
    endfunction

endpackage

### hdl/rspd_front.sv
// front end: configuration registers and pulse classification
// depends on rspd_pkg
module rspd_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rspd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rspd_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic [rspd_pkg::PULSE_W-1:0]      pulse_len,
    output rspd_pkg::pulse_class_t            pulse_class,
    output logic [rspd_pkg::MIL_W-1:0]        max_gap
);
    import rspd_pkg::*;

    logic [CFG_W-1:0] latch1_reg;
    logic [CFG_W-1:0] latch2_reg;
    logic [CFG_W-1:0] bit0_reg;
    logic [CFG_W-1:0] bit1_reg;
    logic [CFG_W-1:0] tol_reg;
    logic [MIL_W-1:0] max_gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch1_reg  <= RST_LATCH1;
            latch2_reg  <= RST_LATCH2;
            bit0_reg    <= RST_BIT0;
            bit1_reg    <= RST_BIT1;
            tol_reg     <= RST_TOLERANCE;
            max_gap_reg <= RST_MAX_GAP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LATCH1:    latch1_reg  <= cfg_wdata;
                REG_LATCH2:    latch2_reg  <= cfg_wdata;
                REG_BIT0:      bit0_reg    <= cfg_wdata;
                REG_BIT1:      bit1_reg    <= cfg_wdata;
                REG_TOLERANCE: tol_reg     <= cfg_wdata;
                REG_MAX_GAP:   max_gap_reg <= cfg_wdata[MIL_W-1:0];
                default:       ;
            endcase
        end
    end

    // four independent window compares
    always_comb
    begin
        pulse_class.near_l1 = near_len(pulse_len, latch1_reg, tol_reg);
        pulse_class.near_l2 = near_len(pulse_len, latch2_reg, tol_reg);
        pulse_class.near_b0 = near_len(pulse_len, bit0_reg, tol_reg);
        pulse_class.near_b1 = near_len(pulse_len, bit1_reg, tol_reg);
    end

    assign max_gap = max_gap_reg;

endmodule

### hdl/rspd_queue.sv
// short queue of classified pulses between front and back
// depends on rspd_pkg
module rspd_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  rspd_pkg::pulse_class_t    push_data,
    input  logic                      pop,
    output rspd_pkg::pulse_class_t    pop_data,
    output rspd_pkg::queue_status_t   status
);
    import rspd_pkg::*;

    pulse_class_t      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data = entry_reg[rd_ptr_reg];

endmodule

### hdl/rspd_back.sv
// back end: latch hunting, bit pair decoding and the result register
// depends on rspd_pkg
module rspd_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              avail,
    input  rspd_pkg::pulse_class_t            pulse_class,
    input  logic [rspd_pkg::MIL_W-1:0]        max_gap,
    output logic                              take,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [rspd_pkg::STATUS_W-1:0]     res_status,
    output logic [rspd_pkg::SENDER_W-1:0]     res_sender,
    output logic                              res_switch_on
);
    import rspd_pkg::*;

    phase_t               phase_reg,  phase_next;
    logic [GAP_W-1:0]     gap_reg,    gap_next;
    logic [BITS_W-1:0]    bits_reg,   bits_next;
    logic [1:0]           half_reg,   half_next;
    logic [HELD_BITS-1:0] shift_reg,  shift_next;

    logic                 valid_reg,  valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [SENDER_W-1:0]  sender_reg, sender_next;
    logic                 sw_reg,     sw_next;

    logic [GAP_W-1:0]     gap_inc;
    logic [1:0]           sym;
    logic [1:0]           first_sym;
    logic [TOP_W-1:0]     top;

    assign take = avail && (!valid_reg || res_ready);

    always_comb
    begin
        if (pulse_class.near_b0)
            sym = SYM_ZERO;
        else if (pulse_class.near_b1)
            sym = SYM_ONE;
        else
            sym = SYM_BAD;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        gap_next    = gap_reg;
        bits_next   = bits_reg;
        half_next   = half_reg;
        shift_next  = shift_reg;
        valid_next  = valid_reg && !res_ready;
        status_next = status_reg;
        sender_next = sender_reg;
        sw_next     = sw_reg;
        gap_inc     = gap_reg + GAP_W'(1);
        first_sym   = half_reg - 2'd1;
        top         = '0;

        if (take)
        begin
            case (phase_reg)
                PH_HUNT1:
                begin
                    if (pulse_class.near_l1)
                    begin
                        gap_next   = '0;
                        bits_next  = '0;
                        half_next  = HALF_NONE;
                        shift_next = '0;
                        phase_next = pulse_class.near_l2 ? PH_DATA : PH_HUNT2;
                    end
                end
                PH_HUNT2:
                begin
                    gap_next = gap_inc;
                    if (pulse_class.near_l2)
                    begin
                        phase_next = PH_DATA;
                        gap_next   = '0;
                        bits_next  = '0;
                        half_next  = HALF_NONE;
                        shift_next = '0;
                    end
                    else if (gap_inc >= (GAP_W'(max_gap) + GAP_W'(1)))
                    begin
                        phase_next  = PH_HUNT1;
                        gap_next    = '0;
                        valid_next  = 1'b1;
                        status_next = ST_NO_LATCH2;
                        sender_next = '0;
                        sw_next     = 1'b0;
                    end
                end
                PH_DATA:
                begin
                    if (half_reg == HALF_NONE)
                    begin
                        half_next = sym + 2'd1;
                    end
                    else
                    begin
                        half_next = HALF_NONE;
                        if (first_sym == SYM_BAD || sym == SYM_BAD || first_sym == sym)
                        begin
                            // bad or equal pair
                            phase_next  = PH_HUNT1;
                            bits_next   = '0;
                            shift_next  = '0;
                            valid_next  = 1'b1;
                            status_next = ST_BAD_PAIR;
                            sender_next = '0;
                            sw_next     = 1'b0;
                        end
                        else
                        begin
                            if (bits_reg < BITS_W'(HELD_BITS))
                                shift_next = {shift_reg[HELD_BITS-2:0], first_sym[0]};
                            bits_next = bits_reg + BITS_W'(1);
                            if (bits_next >= BITS_W'(MSG_BITS))
                            begin
                                top         = shift_next[HELD_BITS-1 -: TOP_W];
                                phase_next  = PH_HUNT1;
                                bits_next   = '0;
                                shift_next  = '0;
                                valid_next  = 1'b1;
                                status_next = ST_OK;
                                sender_next = top[TOP_W-1:1];
                                sw_next     = top[0];
                            end
                        end
                    end
                end
                default:
                begin
                    // unknown phase code: recover by hunting
                    phase_next = PH_HUNT1;
                    gap_next   = '0;
                    bits_next  = '0;
                    half_next  = HALF_NONE;
                    shift_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT1;
            gap_reg   <= '0;
            bits_reg  <= '0;
            half_reg  <= HALF_NONE;
            shift_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            gap_reg   <= gap_next;
            bits_reg  <= bits_next;
            half_reg  <= half_next;
            shift_reg <= shift_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        sender_reg <= sender_next;
        sw_reg     <= sw_next;
    end

    assign res_valid     = valid_reg;
    assign res_status    = status_reg;
    assign res_sender    = sender_reg;
    assign res_switch_on = sw_reg;

endmodule

### hdl/remote_switch_pulse_decoder.sv
// remote switch pulse decoder, top level: front classifier, pulse queue, back decoder
// depends on rspd_pkg, rspd_front, rspd_queue, rspd_back
// a pulse beat is written into a queue entry, then the back end takes it and
// registers its result, which raises m_tvalid
// throughput: one pulse per cycle while no result is held waiting for m_tready
// the four-entry queue accepts up to four beats while a result waits
// reset: asynchronous active-low rst_n, registers back to defaults, decoder hunts latch one
module remote_switch_pulse_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rspd_pkg::S_TDATA_W-1:0]     s_tdata,   // [15:0] pulse_len
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rspd_pkg::M_TDATA_W-1:0]     m_tdata,   // [1:0] status, [12:2] sender,
                                                          // [13] switch_on, [15:14] zero
    // configuration write port
    input  logic                               cfg_we,
    input  logic [rspd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rspd_pkg::CFG_W-1:0]         cfg_wdata
);
    import rspd_pkg::*;

    pulse_class_t   front_class;
    pulse_class_t   queue_class;
    queue_status_t  q_status;
    logic [MIL_W-1:0] max_gap;
    logic           back_take;
    logic [STATUS_W-1:0] res_status;
    logic [SENDER_W-1:0] res_sender;
    logic           res_switch_on;

    // front: config registers and window compares on the incoming beat
    rspd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .pulse_len   (s_tdata[PULSE_W-1:0]),
        .pulse_class (front_class),
        .max_gap     (max_gap)
    );

    // classified pulses wait here until the back end can take them
    rspd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_data (front_class),
        .pop       (back_take),
        .pop_data  (queue_class),
        .status    (q_status)
    );

    assign s_tready = !q_status.full;

    // back: phase tracking, bit pair checks and the result register
    rspd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .avail         (!q_status.empty),
        .pulse_class   (queue_class),
        .max_gap       (max_gap),
        .take          (back_take),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .res_status    (res_status),
        .res_sender    (res_sender),
        .res_switch_on (res_switch_on)
    );

    // pack result beat: status lowest, then sender, then switch_on, zero on top
    assign m_tdata = {{(M_TDATA_W - STATUS_W - SENDER_W - 1){1'b0}},
                      res_switch_on, res_sender, res_status};

    // error results carry no sender or command
    a_err_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_status != ST_OK) |-> (res_sender == '0 && !res_switch_on))
        else $error("error result with nonzero payload");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res_status == ST_OK || res_status == ST_BAD_PAIR
                      || res_status == ST_NO_LATCH2))
        else $error("undefined status code");

    // an accepted push with no pop raises the queue occupancy by one
    a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !back_take) |=> (q_status.count == $past(q_status.count) + 1'b1))
        else $error("queue count lost a push");

    // the back end never pulls from an empty queue
    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        back_take |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule
